/* hw/rtl/quic_datagram_admission_assert.svh */
// Assertion macros for the datagram admission block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef QUIC_DATAGRAM_ADMISSION_ASSERT_SVH
`define QUIC_DATAGRAM_ADMISSION_ASSERT_SVH
`ifndef SYNTHESIS
`define QDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QDA_ASSERT_NOW(label, ante, cons, msg)
`define QDA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hw/rtl/qda_pkg.sv */
// Shared types, constants and helper functions for the datagram admission block.
// No dependencies; imported by every module of the block.
package qda_pkg;

    // Field widths.
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned RATE_W     = 20;
    localparam int unsigned VER_W      = 32;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned TOK_W      = 32;
    localparam int unsigned RLEN_W     = 7;
    localparam int unsigned DISP_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Milli-tokens per token and stateless reset length limits.
    localparam int unsigned MILLI         = 1000;
    localparam int unsigned RESET_MIN_LEN = 21;
    localparam int unsigned RESET_MAX_LEN = 64;

    // A cap is burst * 1000, which stays below 2^30.
    localparam int unsigned CAP_W = 30;

    // Refill arithmetic. Any elapsed time or product at or above 2^40 already
    // exceeds every possible cap, so only 40 bits go through the multiplier.
    localparam int unsigned ELAPSED_W   = 40;
    localparam int unsigned PROD_W      = ELAPSED_W + RATE_W;
    // Division by 1000 is a shift by 3 followed by an exact division by 125
    // through a reciprocal: q = (y * ceil(2^44 / 125)) >> 44 for y < 2^37.
    localparam int unsigned DIV_SHIFT   = 3;
    localparam int unsigned DIVIN_W     = ELAPSED_W - DIV_SHIFT;
    localparam int unsigned RECIP_W     = 38;
    localparam int unsigned RECIP_SHIFT = 44;
    localparam logic [RECIP_W-1:0] RECIP = 38'd140737488356;
    localparam int unsigned SPLIT_W     = 20;
    localparam int unsigned FULL_W      = DIVIN_W + RECIP_W;
    localparam int unsigned GAIN_W      = FULL_W - RECIP_SHIFT;

    typedef enum logic [DISP_W-1:0] {
        DISP_OVERSIZE      = 4'd0,
        DISP_TRUNCATED     = 4'd1,
        DISP_CID_TOO_LONG  = 4'd2,
        DISP_PEER_NEG      = 4'd3,
        DISP_KNOWN_CID     = 4'd4,
        DISP_RESET_SHORT   = 4'd5,
        DISP_NO_BUDGET     = 4'd6,
        DISP_SEND_RESET    = 4'd7,
        DISP_SHORT_INITIAL = 4'd8,
        DISP_SEND_NEG      = 4'd9,
        DISP_NO_TLS        = 4'd10
    } disp_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_TRUNCATED   = 2'd1,
        STATUS_CID_TOO_LONG = 2'd2,
        STATUS_UNKNOWN     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_RATE        = 3'd0,
        CFG_RESET_BURST       = 3'd1,
        CFG_NEG_RATE          = 3'd2,
        CFG_NEG_BURST         = 3'd3,
        CFG_MIN_INITIAL_LEN   = 3'd4,
        CFG_SUPPORTED_VERSION = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0] reset_rate;
        logic [RATE_W-1:0] reset_burst;
        logic [RATE_W-1:0] negotiation_rate;
        logic [RATE_W-1:0] negotiation_burst;
        logic [LEN_W-1:0]  min_initial_len;
        logic [VER_W-1:0]  supported_version;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_rate:        20'd100,
        reset_burst:       20'd200,
        negotiation_rate:  20'd100,
        negotiation_burst: 20'd200,
        min_initial_len:   12'd1200,
        supported_version: 32'd1
    };

    typedef struct packed {
        logic [LEN_W-1:0]    dgram_len;
        logic [STATUS_W-1:0] parse_status;
        logic                is_peer_negotiation;
        logic                cid_known;
        logic                long_form;
        logic [VER_W-1:0]    packet_version;
        logic [TIME_W-1:0]   now_us;
    } item_t;

    // Outcome of classification. disp and rlen hold the result for a granted
    // token; a refused token turns them into no budget and zero.
    typedef struct packed {
        disp_t             disp;
        logic [RLEN_W-1:0] rlen;
        logic              active;   // a limited bucket is spent
        logic              sel_neg;  // negotiation bucket rather than reset bucket
        logic              sat;      // the bucket refills to its cap
    } verdict_t;

    // Load enables of pipeline stages one to five.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // burst * 1000 written as burst * (1024 - 16 - 8).
    function automatic logic [CAP_W-1:0] mul_milli(input logic [RATE_W-1:0] burst);
        logic [CAP_W-1:0] w;
        w = CAP_W'(burst);
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

/* hw/rtl/qda_classify.sv */
// Stage one of the datagram admission pipeline: decision tree, bucket choice,
// elapsed time and the two bucket epochs. Depends on qda_pkg.
module qda_classify
    import qda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pipe_en_t             pipe_en,
    input  item_t                item,
    input  cfg_t                 cfg,
    output verdict_t             verdict,
    output logic [ELAPSED_W-1:0] elapsed,
    output logic [RATE_W-1:0]    rate
);

    logic [TIME_W-1:0]    reset_epoch_reg;
    logic [TIME_W-1:0]    negotiation_epoch_reg;
    verdict_t             verdict_reg;
    verdict_t             verdict_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [RATE_W-1:0]    rate_reg;
    logic [RATE_W-1:0]    rate_next;
    logic                 bucket_path;
    logic [LEN_W-1:0]     len_m1;
    logic [TIME_W-1:0]    epoch_sel;
    logic                 first_use;
    logic [TIME_W:0]      diff;
    logic                 behind;

    assign len_m1 = item.dgram_len - LEN_W'(1);

    always_comb
    begin
        verdict_next         = '0;
        verdict_next.disp    = DISP_NO_TLS;
        bucket_path          = 1'b0;
        if (item.dgram_len == '0)
        begin
            verdict_next.disp = DISP_OVERSIZE;
        end
        else if (item.parse_status == STATUS_CID_TOO_LONG)
        begin
            verdict_next.disp = DISP_CID_TOO_LONG;
        end
        else if (item.parse_status != STATUS_OK)
        begin
            verdict_next.disp = DISP_TRUNCATED;
        end
        else if (item.is_peer_negotiation)
        begin
            verdict_next.disp = DISP_PEER_NEG;
        end
        else if (item.cid_known)
        begin
            verdict_next.disp = DISP_KNOWN_CID;
        end
        else if (!item.long_form)
        begin
            if (item.dgram_len < LEN_W'(RESET_MIN_LEN + 1))
            begin
                verdict_next.disp = DISP_RESET_SHORT;
            end
            else
            begin
                verdict_next.disp = DISP_SEND_RESET;
                verdict_next.rlen = (len_m1 > LEN_W'(RESET_MAX_LEN)) ?
                                    RLEN_W'(RESET_MAX_LEN) : len_m1[RLEN_W-1:0];
                bucket_path       = 1'b1;
            end
        end
        else if (item.dgram_len < cfg.min_initial_len)
        begin
            verdict_next.disp = DISP_SHORT_INITIAL;
        end
        else if (item.packet_version != cfg.supported_version)
        begin
            verdict_next.disp    = DISP_SEND_NEG;
            verdict_next.sel_neg = 1'b1;
            bucket_path          = 1'b1;
        end

        rate_next = verdict_next.sel_neg ? cfg.negotiation_rate : cfg.reset_rate;
        verdict_next.active = bucket_path && (rate_next != '0);

        // A bucket that has not been started takes the current time, so no
        // time has elapsed and it fills to its cap.
        epoch_sel = verdict_next.sel_neg ? negotiation_epoch_reg : reset_epoch_reg;
        first_use = (epoch_sel == '0);
        diff      = {1'b0, item.now_us} - {1'b0, epoch_sel};
        behind    = diff[TIME_W];
        if (first_use || behind)
        begin
            elapsed_next = '0;
        end
        else
        begin
            elapsed_next = diff[ELAPSED_W-1:0];
        end
        verdict_next.sat = first_use ||
                           (!behind && (diff[TIME_W-1:ELAPSED_W] != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_epoch_reg       <= '0;
            negotiation_epoch_reg <= '0;
        end
        else if (pipe_en.s1 && verdict_next.active)
        begin
            if (verdict_next.sel_neg)
            begin
                negotiation_epoch_reg <= item.now_us;
            end
            else
            begin
                reset_epoch_reg <= item.now_us;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.s1)
        begin
            verdict_reg <= verdict_next;
            elapsed_reg <= elapsed_next;
            rate_reg    <= rate_next;
        end
    end

    assign verdict = verdict_reg;
    assign elapsed = elapsed_reg;
    assign rate    = rate_reg;

endmodule

/* hw/rtl/qda_refill.sv */
// Stages two to four of the datagram admission pipeline: rate times elapsed,
// then an exact division by 1000 through reciprocal partial products. Depends on qda_pkg.
module qda_refill
    import qda_pkg::*;
(
    input  logic                 clk,
    input  pipe_en_t             pipe_en,
    input  verdict_t             verdict_in,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic [RATE_W-1:0]    rate,
    output verdict_t             verdict_out,
    output logic [GAIN_W-1:0]    gain
);

    localparam int unsigned YH_W = DIVIN_W - SPLIT_W;
    localparam int unsigned MH_W = RECIP_W - SPLIT_W;

    // Stage two: product.
    verdict_t                      v2_reg;
    logic [PROD_W-1:0]             prod_reg;
    // Stage three: partial products.
    verdict_t                      v3_reg;
    verdict_t                      v3_next;
    logic [YH_W+MH_W-1:0]          pp_hh_reg;
    logic [YH_W+SPLIT_W-1:0]       pp_hl_reg;
    logic [SPLIT_W+MH_W-1:0]       pp_lh_reg;
    logic [2*SPLIT_W-1:0]          pp_ll_reg;
    // Stage four: quotient.
    verdict_t                      v4_reg;
    logic [GAIN_W-1:0]             gain_reg;

    logic [DIVIN_W-1:0]            divin;
    logic [YH_W-1:0]               y_hi;
    logic [SPLIT_W-1:0]            y_lo;
    logic [MH_W-1:0]               m_hi;
    logic [SPLIT_W-1:0]            m_lo;
    logic [FULL_W-1:0]             full;

    always_ff @(posedge clk)
    begin
        if (pipe_en.s2)
        begin
            v2_reg   <= verdict_in;
            prod_reg <= PROD_W'(elapsed) * PROD_W'(rate);
        end
    end

    // Dropping the low three bits divides by eight; the reciprocal does the 125.
    always_comb
    begin
        divin       = prod_reg[ELAPSED_W-1:DIV_SHIFT];
        y_hi        = divin[DIVIN_W-1:SPLIT_W];
        y_lo        = divin[SPLIT_W-1:0];
        m_hi        = RECIP[RECIP_W-1:SPLIT_W];
        m_lo        = RECIP[SPLIT_W-1:0];
        v3_next     = v2_reg;
        v3_next.sat = v2_reg.sat || (prod_reg[PROD_W-1:ELAPSED_W] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.s3)
        begin
            v3_reg    <= v3_next;
            pp_hh_reg <= (YH_W+MH_W)'(y_hi) * (YH_W+MH_W)'(m_hi);
            pp_hl_reg <= (YH_W+SPLIT_W)'(y_hi) * (YH_W+SPLIT_W)'(m_lo);
            pp_lh_reg <= (SPLIT_W+MH_W)'(y_lo) * (SPLIT_W+MH_W)'(m_hi);
            pp_ll_reg <= (2*SPLIT_W)'(y_lo) * (2*SPLIT_W)'(m_lo);
        end
    end

    assign full = (FULL_W'(pp_hh_reg) << (2 * SPLIT_W))
                + (FULL_W'(pp_hl_reg) << SPLIT_W)
                + (FULL_W'(pp_lh_reg) << SPLIT_W)
                + FULL_W'(pp_ll_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en.s4)
        begin
            v4_reg   <= v3_reg;
            gain_reg <= full[FULL_W-1:RECIP_SHIFT];
        end
    end

    assign verdict_out = v4_reg;
    assign gain        = gain_reg;

endmodule

/* hw/rtl/qda_bucket.sv */
// Stage five of the datagram admission pipeline: token state of both buckets,
// the grant decision and the result register. Depends on qda_pkg.
module qda_bucket
    import qda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_en_t          pipe_en,
    input  verdict_t          verdict,
    input  logic [GAIN_W-1:0] gain,
    input  cfg_t              cfg,
    output logic [DISP_W-1:0] disposition,
    output logic [RLEN_W-1:0] reply_len
);

    logic [TOK_W-1:0]  reset_tokens_reg;
    logic [TOK_W-1:0]  negotiation_tokens_reg;
    logic [CAP_W-1:0]  reset_cap_reg;
    logic [CAP_W-1:0]  negotiation_cap_reg;
    logic [DISP_W-1:0] disp_reg;
    logic [DISP_W-1:0] disp_next;
    logic [RLEN_W-1:0] rlen_reg;
    logic [RLEN_W-1:0] rlen_next;

    logic [TOK_W-1:0]  tok_sel;
    logic [CAP_W-1:0]  cap_sel;
    logic [TOK_W:0]    sum;
    logic [TOK_W-1:0]  filled;
    logic              grant;
    logic [TOK_W-1:0]  tokens_next;

    always_comb
    begin
        tok_sel = verdict.sel_neg ? negotiation_tokens_reg : reset_tokens_reg;
        cap_sel = verdict.sel_neg ? negotiation_cap_reg : reset_cap_reg;
        sum     = (TOK_W+1)'(tok_sel) + (TOK_W+1)'(gain);
        // A bucket above its cap (burst lowered) is cut back to the cap here too.
        if (verdict.sat || (sum >= (TOK_W+1)'(cap_sel)))
        begin
            filled = TOK_W'(cap_sel);
        end
        else
        begin
            filled = sum[TOK_W-1:0];
        end
        grant       = (filled >= TOK_W'(MILLI));
        tokens_next = grant ? (filled - TOK_W'(MILLI)) : filled;

        if (verdict.active && !grant)
        begin
            disp_next = DISP_NO_BUDGET;
            rlen_next = '0;
        end
        else
        begin
            disp_next = verdict.disp;
            rlen_next = verdict.rlen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_tokens_reg       <= '0;
            negotiation_tokens_reg <= '0;
            reset_cap_reg          <= mul_milli(CFG_RESET.reset_burst);
            negotiation_cap_reg    <= mul_milli(CFG_RESET.negotiation_burst);
        end
        else
        begin
            reset_cap_reg       <= mul_milli(cfg.reset_burst);
            negotiation_cap_reg <= mul_milli(cfg.negotiation_burst);
            if (pipe_en.s5 && verdict.active)
            begin
                if (verdict.sel_neg)
                begin
                    negotiation_tokens_reg <= tokens_next;
                end
                else
                begin
                    reset_tokens_reg <= tokens_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.s5)
        begin
            disp_reg <= disp_next;
            rlen_reg <= rlen_next;
        end
    end

    assign disposition = disp_reg;
    assign reply_len   = rlen_reg;

endmodule

/* hw/rtl/quic_datagram_admission.sv */
// Top level of the QUIC datagram admission block: configuration registers,
// input register, pipeline control and the three pipeline modules.
// Depends on qda_pkg, qda_classify, qda_refill, qda_bucket and the assert header.
//
//   Channel  Direction  Handshake                Word
//   cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//   in       in         in_valid / in_stall      dgram_len .. now_us
//   out      out        out_valid / out_stall    disposition, reply_len
//
// One datagram word can be taken in every cycle while in_stall is low.
// Its result passes through registers for classification, the refill product, the
// partial products and the quotient of the divide by 1000, and the bucket update.
// rst_n restores the configuration defaults, empties the pipeline and leaves both
// buckets unstarted. An output stall freezes only full stages, so bubbles close up
// and words are taken until all six stages hold one; cfg_ready is always high.
`include "quic_datagram_admission_assert.svh"

module quic_datagram_admission
    import qda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Datagram words.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEN_W-1:0]      dgram_len,
    input  logic [STATUS_W-1:0]   parse_status,
    input  logic                  is_peer_negotiation,
    input  logic                  cid_known,
    input  logic                  long_form,
    input  logic [VER_W-1:0]      packet_version,
    input  logic [TIME_W-1:0]     now_us,
    // Result words.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DISP_W-1:0]     disposition,
    output logic [RLEN_W-1:0]     reply_len
);

    // Stage 0 is the input register, stage 5 the result register.
    localparam int unsigned NUM_STAGES = 6;
    localparam int unsigned LAST       = NUM_STAGES - 1;

    cfg_t                    cfg_reg;
    item_t                   item_reg;
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES-1:0]   valid_next;
    logic [NUM_STAGES-1:0]   ready;
    pipe_en_t                pipe_en;
    logic                    in_load;

    verdict_t                cls_verdict;
    logic [ELAPSED_W-1:0]    cls_elapsed;
    logic [RATE_W-1:0]       cls_rate;
    verdict_t                ref_verdict;
    logic [GAIN_W-1:0]       ref_gain;

    // Configuration registers; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RESET_RATE:        cfg_reg.reset_rate        <= cfg_data[RATE_W-1:0];
                CFG_RESET_BURST:       cfg_reg.reset_burst       <= cfg_data[RATE_W-1:0];
                CFG_NEG_RATE:          cfg_reg.negotiation_rate  <= cfg_data[RATE_W-1:0];
                CFG_NEG_BURST:         cfg_reg.negotiation_burst <= cfg_data[RATE_W-1:0];
                CFG_MIN_INITIAL_LEN:   cfg_reg.min_initial_len   <= cfg_data[LEN_W-1:0];
                CFG_SUPPORTED_VERSION: cfg_reg.supported_version <= cfg_data[VER_W-1:0];
                default:               ;
            endcase
        end
    end

    // Each stage can take a word when it is empty or when its own word moves
    // on, so a stall ripples back only through full stages.
    always_comb
    begin
        ready[LAST] = !valid_reg[LAST] || !out_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign in_load    = ready[0] && in_valid;
    assign pipe_en.s1 = ready[1] && valid_reg[0];
    assign pipe_en.s2 = ready[2] && valid_reg[1];
    assign pipe_en.s3 = ready[3] && valid_reg[2];
    assign pipe_en.s4 = ready[4] && valid_reg[3];
    assign pipe_en.s5 = ready[5] && valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            item_reg.dgram_len           <= dgram_len;
            item_reg.parse_status        <= parse_status;
            item_reg.is_peer_negotiation <= is_peer_negotiation;
            item_reg.cid_known           <= cid_known;
            item_reg.long_form           <= long_form;
            item_reg.packet_version      <= packet_version;
            item_reg.now_us              <= now_us;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[LAST];

    qda_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .pipe_en (pipe_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .verdict (cls_verdict),
        .elapsed (cls_elapsed),
        .rate    (cls_rate)
    );

    qda_refill u_refill (
        .clk         (clk),
        .pipe_en     (pipe_en),
        .verdict_in  (cls_verdict),
        .elapsed     (cls_elapsed),
        .rate        (cls_rate),
        .verdict_out (ref_verdict),
        .gain        (ref_gain)
    );

    qda_bucket u_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .pipe_en     (pipe_en),
        .verdict     (ref_verdict),
        .gain        (ref_gain),
        .cfg         (cfg_reg),
        .disposition (disposition),
        .reply_len   (reply_len)
    );

    // Only a stateless reset carries a reply length.
    `QDA_ASSERT_NOW(a_rlen_only_on_reset,
        out_valid && (disposition != DISP_SEND_RESET),
        reply_len == '0,
        "reply length set on a result that is not a stateless reset")
    `QDA_ASSERT_NOW(a_rlen_range,
        out_valid && (disposition == DISP_SEND_RESET),
        (reply_len >= RLEN_W'(RESET_MIN_LEN)) && (reply_len <= RLEN_W'(RESET_MAX_LEN)),
        "stateless reset length out of range")
    `QDA_ASSERT_NOW(a_ready_chain,
        !out_stall,
        !in_stall,
        "input stalled although the output is free")
    `QDA_ASSERT_NEXT(a_no_loss_when_full,
        valid_reg[LAST-1] && valid_reg[LAST] && out_stall,
        valid_reg[LAST-1] && valid_reg[LAST],
        "word lost in the last two stages during an output stall")

endmodule
